[rtl/tod_pkg.sv]
// ---------------------------------------------------------------------------
// tod_pkg: shared types and helpers for the time-of-day clock
// Payload structs for both channels, the clock state record, the counting
// limits and small wrap and digit-split helpers.
// ---------------------------------------------------------------------------
package tod_pkg;

  // Counting limits.
  localparam logic [9:0]  MsDeltaMax = 10'd999;
  localparam logic [10:0] MsPerSec   = 11'd1000;
  localparam logic [5:0]  SecMax     = 6'd59;
  localparam logic [5:0]  MinMax     = 6'd59;
  localparam logic [5:0]  HourMax    = 6'd23;
  localparam logic [3:0]  DigitBase  = 4'd10;
  localparam int          NumButtons = 6;

  // One input beat.
  typedef struct packed {
    logic [9:0] delta_ms;
    logic       hour_down_btn;
    logic       hour_up_btn;
    logic       minute_down_btn;
    logic       minute_up_btn;
    logic       second_down_btn;
    logic       second_up_btn;
  } tod_in_t;

  // One result beat.
  typedef struct packed {
    logic [3:0] sec_units;
    logic [2:0] sec_tens;
    logic [3:0] min_units;
    logic [2:0] min_tens;
    logic [3:0] hour_units;
    logic [1:0] hour_tens;
  } tod_out_t;

  // Running clock state. Bit 0 of released is hour down, bit 5 second up.
  typedef struct packed {
    logic [4:0]            hours;
    logic [5:0]            minutes;
    logic [5:0]            seconds;
    logic [9:0]            ms;
    logic [NumButtons-1:0] released;
  } tod_state_t;

  // Decimal split of a value below 60.
  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } tod_digits_t;

  // Step up by one, wrapping from max to zero.
  function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] max);
    logic [5:0] r;
    if (v >= max) begin
      r = 6'd0;
    end else begin
      r = v + 6'd1;
    end
    return r;
  endfunction

  // Step down by one, wrapping from zero to max.
  function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] max);
    logic [5:0] r;
    if (v == 6'd0) begin
      r = max;
    end else begin
      r = v - 6'd1;
    end
    return r;
  endfunction

  // Split 0..59 into tens and units with a short compare chain.
  function automatic tod_digits_t split_digits(input logic [5:0] v);
    tod_digits_t d;
    logic [5:0]  base;
    if (v >= 6'd50) begin
      d.tens = 3'd5;
    end else if (v >= 6'd40) begin
      d.tens = 3'd4;
    end else if (v >= 6'd30) begin
      d.tens = 3'd3;
    end else if (v >= 6'd20) begin
      d.tens = 3'd2;
    end else if (v >= 6'd10) begin
      d.tens = 3'd1;
    end else begin
      d.tens = 3'd0;
    end
    base    = 6'(d.tens * DigitBase);
    d.units = 4'(v - base);
    return d;
  endfunction

endpackage

[rtl/tod_update.sv]
// ---------------------------------------------------------------------------
// tod_update: next-state and result logic for one beat
// Adds the elapsed milliseconds, ticks and carries the hh:mm:ss counters,
// splits the ticked time into digits, then applies newly pressed buttons.
// ---------------------------------------------------------------------------
module tod_update (
  input  tod_pkg::tod_state_t cur,
  input  tod_pkg::tod_in_t    item,
  output tod_pkg::tod_state_t nxt,
  output tod_pkg::tod_out_t   res
);

  logic [9:0]                     delta_sat;
  logic [10:0]                    ms_sum;
  logic                           tick;
  logic                           sec_wrap;
  logic                           min_wrap;
  logic [5:0]                     hours_up;
  logic [4:0]                     hours_t;
  logic [5:0]                     minutes_t;
  logic [5:0]                     seconds_t;
  logic [tod_pkg::NumButtons-1:0] pressed;
  logic [tod_pkg::NumButtons-1:0] rise;
  logic [5:0]                     h_a;
  logic [5:0]                     h_b;
  logic [5:0]                     m_a;
  logic [5:0]                     m_b;
  logic [5:0]                     s_a;
  logic [5:0]                     s_b;
  tod_pkg::tod_digits_t           sec_d;
  tod_pkg::tod_digits_t           min_d;
  tod_pkg::tod_digits_t           hour_d;

  // Millisecond accumulation; a delta over range is clamped.
  always_comb begin
    delta_sat = (item.delta_ms > tod_pkg::MsDeltaMax) ? tod_pkg::MsDeltaMax : item.delta_ms;
    ms_sum    = {1'b0, cur.ms} + {1'b0, delta_sat};
    tick      = (ms_sum >= tod_pkg::MsPerSec);
  end

  // One-second tick with carry from seconds to minutes to hours.
  always_comb begin
    sec_wrap  = tick && (cur.seconds >= tod_pkg::SecMax);
    min_wrap  = sec_wrap && (cur.minutes >= tod_pkg::MinMax);
    seconds_t = tick ? tod_pkg::wrap_up(cur.seconds, tod_pkg::SecMax) : cur.seconds;
    minutes_t = sec_wrap ? tod_pkg::wrap_up(cur.minutes, tod_pkg::MinMax) : cur.minutes;
    hours_up  = tod_pkg::wrap_up({1'b0, cur.hours}, tod_pkg::HourMax);
    hours_t   = min_wrap ? hours_up[4:0] : cur.hours;
  end

  // Digits reflect the ticked time, before any button acts.
  always_comb begin
    sec_d          = tod_pkg::split_digits(seconds_t);
    min_d          = tod_pkg::split_digits(minutes_t);
    hour_d         = tod_pkg::split_digits({1'b0, hours_t});
    res.sec_units  = sec_d.units;
    res.sec_tens   = sec_d.tens;
    res.min_units  = min_d.units;
    res.min_tens   = min_d.tens;
    res.hour_units = hour_d.units;
    res.hour_tens  = hour_d.tens[1:0];
  end

  // Newly pressed buttons: down acts before up within each field.
  always_comb begin
    pressed = {item.second_up_btn, item.second_down_btn, item.minute_up_btn,
               item.minute_down_btn, item.hour_up_btn, item.hour_down_btn};
    rise    = pressed & cur.released;
    h_a = rise[0] ? tod_pkg::wrap_down({1'b0, hours_t}, tod_pkg::HourMax) : {1'b0, hours_t};
    h_b = rise[1] ? tod_pkg::wrap_up(h_a, tod_pkg::HourMax) : h_a;
    m_a = rise[2] ? tod_pkg::wrap_down(minutes_t, tod_pkg::MinMax) : minutes_t;
    m_b = rise[3] ? tod_pkg::wrap_up(m_a, tod_pkg::MinMax) : m_a;
    s_a = rise[4] ? tod_pkg::wrap_down(seconds_t, tod_pkg::SecMax) : seconds_t;
    s_b = rise[5] ? tod_pkg::wrap_up(s_a, tod_pkg::SecMax) : s_a;
    nxt.ms       = tick ? 10'(ms_sum - tod_pkg::MsPerSec) : ms_sum[9:0];
    nxt.hours    = h_b[4:0];
    nxt.minutes  = m_b;
    nxt.seconds  = s_b;
    // A button is released again as soon as its level drops.
    nxt.released = ~pressed;
  end

endmodule

[rtl/time_of_day_clock_with_set_buttons_core.sv]
// ---------------------------------------------------------------------------
// time_of_day_clock_with_set_buttons_core: 24-hour clock with set buttons
// Each beat adds elapsed milliseconds, ticks hh:mm:ss on a full second,
// reports the six time digits and applies newly pressed set buttons.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   tod_pkg::tod_in_t  (delta, buttons)
//   out_     output     out_valid / out_ready tod_pkg::tod_out_t (six digits)
//
// One beat is accepted per clock cycle unless the output stalls; its result is
// offered once the beat moves from the input register into the result register,
// when that register is free or emptying. The clock state updates on that same
// edge, so the next beat sees it at once. Reset clears the time to 00:00:00 and
// the millisecond count, and marks every button released. A stalled output holds
// its beat; the input register still takes one more beat before in_ready drops.
module time_of_day_clock_with_set_buttons_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tod_pkg::tod_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tod_pkg::tod_out_t out_data
);

  logic                s1_valid_r;
  tod_pkg::tod_in_t    s1_data_r;
  logic                out_valid_r;
  tod_pkg::tod_out_t   out_data_r;
  tod_pkg::tod_state_t state_r;
  tod_pkg::tod_state_t state_nxt;
  tod_pkg::tod_out_t   res;
  logic                advance;

  // An item moves on when the result register is free or being emptied.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Next-state and result logic for the item in the input register.
  tod_update u_update (
    .cur  (state_r),
    .item (s1_data_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // Control state and clock counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      state_r.hours    <= '0;
      state_r.minutes  <= '0;
      state_r.seconds  <= '0;
      state_r.ms       <= '0;
      state_r.released <= '1;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  // The counters never leave their ranges.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.seconds <= tod_pkg::SecMax) && (state_r.minutes <= tod_pkg::MinMax) &&
    (state_r.hours <= 5'(tod_pkg::HourMax)) && (state_r.ms < 10'(tod_pkg::MsPerSec)))
    else $error("clock counter out of range");

  // A shown result always carries valid decimal digits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.sec_units <= 4'd9) && (out_data_r.sec_tens <= 3'd5) &&
      (out_data_r.min_units <= 4'd9) && (out_data_r.min_tens <= 3'd5) &&
      (out_data_r.hour_units <= 4'd9) && (out_data_r.hour_tens <= 2'd2))
    else $error("result digit out of range");

  // The clock state moves only when an item is processed.
  assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(state_r))
    else $error("clock state changed without an item");

  // Back-pressure on the input only while the input register is occupied.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without cause");

endmodule

[tb/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: testbench for the 24-hour time-of-day clock with set buttons
// Drives beats of elapsed milliseconds and button levels into the core and
// predicts every result with its own model of the clock: the millisecond
// accumulator, the hh:mm:ss carry chain and the edge-detected set buttons.
// Each result beat is checked digit by digit against the oldest prediction,
// under random idling on both channels and deliberate back-pressure.
// ---------------------------------------------------------------------------
module tb_top;

  // Limits of the clock, as counted by the predictor.
  localparam int MsPerSecond    = 1000;
  localparam int DeltaLimit     = 999;
  localparam int SecondsPerMin  = 60;
  localparam int MinutesPerHour = 60;
  localparam int HoursPerDay    = 24;

  // Button masks; bit 0 is hour down, bit 5 second up.
  localparam logic [5:0] NoBtns      = 6'b000000;
  localparam logic [5:0] BtnHourDown = 6'b000001;
  localparam logic [5:0] BtnHourUp   = 6'b000010;
  localparam logic [5:0] BtnMinDown  = 6'b000100;
  localparam logic [5:0] BtnMinUp    = 6'b001000;
  localparam logic [5:0] BtnSecDown  = 6'b010000;
  localparam logic [5:0] BtnSecUp    = 6'b100000;
  localparam logic [5:0] AllBtns     = 6'b111111;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  tod_pkg::tod_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  tod_pkg::tod_out_t out_data;

  // Predicted clock state and the digits still owed by the core.
  tod_pkg::tod_state_t clock_model;
  tod_pkg::tod_out_t   expected_digits[$];
  tod_pkg::tod_out_t   want;

  int         error_count   = 0;
  bit         gaps_on       = 1'b1;
  int         hold_off_left = 0;
  logic [5:0] btn_levels    = NoBtns;

  time_of_day_clock_with_set_buttons_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Step a field by one within 0..modulus-1, wrapping at both ends.
  function automatic int roll(input int v, input int modulus, input bit up);
    if (up) begin
      return (v + 1 >= modulus) ? 0 : v + 1;
    end
    return (v == 0) ? modulus - 1 : v - 1;
  endfunction

  // Apply one accepted beat to the clock model and return the digits shown.
  function automatic tod_pkg::tod_out_t advance_clock(input tod_pkg::tod_in_t beat);
    tod_pkg::tod_out_t shown;
    int                delta;
    int                ms;
    int                hrs;
    int                mins;
    int                secs;
    logic [5:0]        levels;
    delta = int'(beat.delta_ms);
    if (delta > DeltaLimit) begin
      delta = DeltaLimit;
    end
    ms   = int'(clock_model.ms) + delta;
    hrs  = int'(clock_model.hours);
    mins = int'(clock_model.minutes);
    secs = int'(clock_model.seconds);

    // A full second ticks the carry chain.
    if (ms >= MsPerSecond) begin
      ms   -= MsPerSecond;
      secs += 1;
      if (secs >= SecondsPerMin) begin
        secs = 0;
        mins += 1;
        if (mins >= MinutesPerHour) begin
          mins = 0;
          hrs  = (hrs + 1 >= HoursPerDay) ? 0 : hrs + 1;
        end
      end
    end

    shown.sec_units  = 4'(secs % 10);
    shown.sec_tens   = 3'(secs / 10);
    shown.min_units  = 4'(mins % 10);
    shown.min_tens   = 3'(mins / 10);
    shown.hour_units = 4'(hrs % 10);
    shown.hour_tens  = 2'(hrs / 10);

    // Newly pressed buttons act in order, each on the value left before it.
    levels = {beat.second_up_btn, beat.second_down_btn, beat.minute_up_btn,
              beat.minute_down_btn, beat.hour_up_btn, beat.hour_down_btn};
    for (int b = 0; b < tod_pkg::NumButtons; b++) begin
      if (!levels[b]) begin
        clock_model.released[b] = 1'b1;
      end else if (clock_model.released[b]) begin
        clock_model.released[b] = 1'b0;
        if (b < 2) begin
          hrs = roll(hrs, HoursPerDay, b % 2 == 1);
        end else if (b < 4) begin
          mins = roll(mins, MinutesPerHour, b % 2 == 1);
        end else begin
          secs = roll(secs, SecondsPerMin, b % 2 == 1);
        end
      end
    end

    clock_model.ms      = 10'(ms);
    clock_model.hours   = 5'(hrs);
    clock_model.minutes = 6'(mins);
    clock_model.seconds = 6'(secs);
    return shown;
  endfunction

  function automatic tod_pkg::tod_in_t make_beat(input int delta, input logic [5:0] btns);
    tod_pkg::tod_in_t beat;
    beat.delta_ms        = 10'(delta);
    beat.hour_down_btn   = btns[0];
    beat.hour_up_btn     = btns[1];
    beat.minute_down_btn = btns[2];
    beat.minute_up_btn   = btns[3];
    beat.second_down_btn = btns[4];
    beat.second_up_btn   = btns[5];
    return beat;
  endfunction

  // Button levels mostly stay put, so presses, holds and releases all occur;
  // now and then every level is scrambled at once.
  function automatic tod_pkg::tod_in_t random_beat();
    int delta;
    if ($urandom_range(0, 39) == 0) begin
      btn_levels = 6'($urandom);
    end else begin
      for (int b = 0; b < tod_pkg::NumButtons; b++) begin
        if ($urandom_range(0, 7) == 0) begin
          btn_levels[b] = ~btn_levels[b];
        end
      end
    end
    case ($urandom_range(0, 9))
      0:       delta = $urandom_range(1000, 1023);
      1:       delta = $urandom_range(0, 1023);
      2:       delta = $urandom_range(0, 1) ? 0 : DeltaLimit;
      default: delta = $urandom_range(0, DeltaLimit);
    endcase
    return make_beat(delta, btn_levels);
  endfunction

  // Offer one beat, wait for it to be taken, then maybe leave a gap.
  task automatic send_beat(input tod_pkg::tod_in_t beat);
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_digits.push_back(advance_clock(beat));
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_digits.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic press_repeatedly(input logic [5:0] btn, input int count);
    repeat (count) begin
      send_beat(make_beat(0, btn));
      send_beat(make_beat(0, NoBtns));
    end
  endtask

  // Walk each field to its target the short way round, with no ticks.
  task automatic set_time_by_buttons(input int hh, input int mm, input int ss);
    int diff;
    send_beat(make_beat(0, NoBtns));
    diff = (hh - int'(clock_model.hours) + HoursPerDay) % HoursPerDay;
    if (diff <= HoursPerDay / 2) begin
      press_repeatedly(BtnHourUp, diff);
    end else begin
      press_repeatedly(BtnHourDown, HoursPerDay - diff);
    end
    diff = (mm - int'(clock_model.minutes) + MinutesPerHour) % MinutesPerHour;
    if (diff <= MinutesPerHour / 2) begin
      press_repeatedly(BtnMinUp, diff);
    end else begin
      press_repeatedly(BtnMinDown, MinutesPerHour - diff);
    end
    diff = (ss - int'(clock_model.seconds) + SecondsPerMin) % SecondsPerMin;
    if (diff <= SecondsPerMin / 2) begin
      press_repeatedly(BtnSecUp, diff);
    end else begin
      press_repeatedly(BtnSecDown, SecondsPerMin - diff);
    end
  endtask

  // Millisecond edges, saturation and every button alone and together.
  task automatic test_directed_corners();
    send_beat(make_beat(0, NoBtns));
    send_beat(make_beat(DeltaLimit, NoBtns));
    send_beat(make_beat(1, NoBtns));
    send_beat(make_beat(1023, NoBtns));
    send_beat(make_beat(1000, NoBtns));
    // Hour down from hour zero wraps; holding it does nothing more.
    send_beat(make_beat(0, BtnHourDown));
    send_beat(make_beat(0, BtnHourDown));
    send_beat(make_beat(0, NoBtns));
    send_beat(make_beat(0, BtnHourUp));
    send_beat(make_beat(0, BtnMinDown));
    send_beat(make_beat(0, BtnMinUp));
    send_beat(make_beat(0, BtnSecDown));
    send_beat(make_beat(0, BtnSecUp));
    send_beat(make_beat(512, NoBtns));
    // Opposite buttons pressed together cancel out.
    send_beat(make_beat(0, BtnHourDown | BtnHourUp));
    send_beat(make_beat(0, NoBtns));
    send_beat(make_beat(999, AllBtns));
    send_beat(make_beat(999, AllBtns));
    send_beat(make_beat(0, NoBtns));
    send_beat(make_beat(0, BtnSecDown | BtnMinUp | BtnHourDown));
    send_beat(make_beat(1023, AllBtns));
    send_beat(make_beat(0, NoBtns));
    wait_results_drained();
  endtask

  // Carries across minute, hour and day boundaries.
  task automatic test_day_rollover();
    int targets[3][3] = '{'{23, 59, 58}, '{9, 59, 59}, '{19, 59, 59}};
    foreach (targets[t]) begin
      set_time_by_buttons(targets[t][0], targets[t][1], targets[t][2]);
      send_beat(make_beat(DeltaLimit, NoBtns));
      send_beat(make_beat(1, NoBtns));
      send_beat(make_beat(DeltaLimit, NoBtns));
      send_beat(make_beat(1, NoBtns));
      repeat (4) send_beat(make_beat($urandom_range(500, 1023), NoBtns));
    end
    wait_results_drained();
  endtask

  // The receiver holds off long enough for the core to fill and stall.
  task automatic test_output_hold_off();
    hold_off_left = 120;
    repeat (40) send_beat(random_beat());
    wait_results_drained();
  endtask

  // Short bursts, each one fully drained before the next begins.
  task automatic test_sender_pause();
    repeat (6) begin
      repeat ($urandom_range(1, 10)) send_beat(random_beat());
      wait_results_drained();
    end
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) send_beat(random_beat());
    wait_results_drained();
  endtask

  // Full rate on both channels to close the run.
  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    repeat (count) send_beat(random_beat());
    wait_results_drained();
  endtask

  // Receiver: random ready pattern, plus a long hold-off on request.
  initial begin
    int  left;
    bit  ready_now;
    left      = 0;
    ready_now = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        ready_now = 1'b0;
        hold_off_left--;
      end else if (left > 0) begin
        left--;
      end else if (gaps_on && ready_now && $urandom_range(0, 3) == 0) begin
        ready_now = 1'b0;
        left      = $urandom_range(0, 18);
      end else begin
        ready_now = 1'b1;
        left      = $urandom_range(0, 39);
      end
      out_ready <= ready_now;
    end
  end

  task automatic check_digit(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      error_count++;
    end
  endtask

  // Every result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = expected_digits.pop_front();
        check_digit("sec_units", want.sec_units, out_data.sec_units);
        check_digit("sec_tens", want.sec_tens, out_data.sec_tens);
        check_digit("min_units", want.min_units, out_data.min_units);
        check_digit("min_tens", want.min_tens, out_data.min_tens);
        check_digit("hour_units", want.hour_units, out_data.hour_units);
        check_digit("hour_tens", want.hour_tens, out_data.hour_tens);
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("%0t: timeout, %0d results still expected", $time, expected_digits.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    clock_model          = '0;
    clock_model.released = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_corners();
    test_day_rollover();
    test_output_hold_off();
    test_sender_pause();
    test_random_traffic(1100);
    test_back_to_back(200);

    // Let any stray beat surface before the verdict.
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tod_pkg.sv
rtl/tod_update.sv
rtl/time_of_day_clock_with_set_buttons_core.sv
tb/tb_top.sv
